// ===== hdl/wdf_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wdf_pkg: shared types and constants of the word duplicate filter
// Sizes of the stores, beat formats and the verdict codes.
// ---------------------------------------------------------------------------
package wdf_pkg;

	localparam int HASH_BITS_MAX = 16;
	localparam int BUCKETS       = 1 << HASH_BITS_MAX;
	localparam int ENTRIES       = 4096;
	localparam int STORE_BYTES   = 65536;
	localparam int MAX_WORD      = 128;

	localparam int IDX_W  = 12;
	localparam int CNT_W  = 13;
	localparam int BKT_W  = 16;
	localparam int ADDR_W = 16;
	localparam int FILL_W = 17;
	localparam int LEN_W  = 8;
	localparam int WB_AW  = 7;

	localparam logic [1:0] VERDICT_NEW  = 2'd0;
	localparam logic [1:0] VERDICT_DUP  = 2'd1;
	localparam logic [1:0] VERDICT_FULL = 2'd2;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       byte_present;
		logic       end_of_word;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       verdict;
		logic [BKT_W-1:0] bucket;
		logic [IDX_W-1:0] entry_index;
	} result_t;

	typedef struct packed {
		logic [BKT_W-1:0] bucket;
		logic [LEN_W-1:0] len;
	} job_t;

	typedef struct packed {
		logic             en;
		logic [WB_AW-1:0] addr;
		logic [7:0]       data;
	} wb_wr_t;

	// Out-of-range register values are clamped to the supported span.
	function automatic logic [4:0] eff_bits(input logic [4:0] r);
		logic [4:0] v;
		v = r;
		if (r == 5'd0) v = 5'd1;
		if (r > 5'(HASH_BITS_MAX)) v = 5'(HASH_BITS_MAX);
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/word_duplicate_filter.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// word_duplicate_filter: hashed duplicate filter for byte-serial words
// Hashes incoming words, looks them up in a chained table and stores new ones.
// ---------------------------------------------------------------------------
// After reset the block clears its 65536 bucket heads, one a cycle, and holds
// busy high while it does so. A byte beat is taken whenever start is high and
// busy is low. The beat that ends a word is followed by a step to finish the
// hash, one to hand the word to the back end and one to read the bucket head.
// Each stored word compared is then read back from the byte store one byte at
// a time, the terminating zero included, up to the first mismatch, and a last
// check closes the walk when the chain runs out. A decision step follows; a new
// word is then copied into the byte store and linked, and the result strobe is
// given.
// Busy stays high until the result strobe has been given; the result is on
// the ports for that single cycle and cannot be held off.
module word_duplicate_filter (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire wdf_pkg::in_item_t item,
	output logic                  busy,
	input  wire logic             cfg_we,
	input  wire logic [4:0]       cfg_wdata,
	output logic                  result_valid,
	output wdf_pkg::result_t      result
);
	import wdf_pkg::*;

	logic [4:0] hash_bits_q;
	logic       back_busy, job_take, job_valid;
	wb_wr_t     wb_wr;
	job_t       job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hash_bits_q <= 5'd16;
		else if (cfg_we) hash_bits_q <= cfg_wdata;
	end

	wdf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.hash_bits (hash_bits_q),
		.back_busy (back_busy),
		.job_take  (job_take),
		.busy      (busy),
		.wb_wr     (wb_wr),
		.job_valid (job_valid),
		.job       (job)
	);

	wdf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.wb_wr        (wb_wr),
		.job_valid    (job_valid),
		.job          (job),
		.job_take     (job_take),
		.back_busy    (back_busy),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== hdl/wdf_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wdf_front: byte intake and hashing
// Absorbs bytes into the two hash accumulators, forwards them to the word
// buffer and hands a finished word to the back end through a one-slot queue.
// ---------------------------------------------------------------------------
module wdf_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire wdf_pkg::in_item_t item,
	input  wire logic [4:0]      hash_bits,
	input  wire logic            back_busy,
	input  wire logic            job_take,
	output logic                 busy,
	output wdf_pkg::wb_wr_t      wb_wr,
	output logic                 job_valid,
	output wdf_pkg::job_t        job
);
	import wdf_pkg::*;

	logic [31:0]      hash_q, extra_q, hash_n, extra_n, mask, hf;
	logic [LEN_W-1:0] cnt_q;
	logic             fin_q, job_q, accept, absorb;
	logic [4:0]       hb;
	job_t             job_q_data;

	assign busy   = fin_q | job_q | back_busy;
	assign accept = start & ~busy;
	assign hb     = eff_bits(hash_bits);
	assign mask   = ~(32'hFFFFFFFF << hb);
	assign absorb = accept & item.byte_present & (item.char_byte != 8'd0)
		& (cnt_q < LEN_W'(MAX_WORD));

	always_comb begin
		hash_n  = hash_q;
		extra_n = extra_q;
		if (cnt_q == '0) begin
			hash_n = {24'd0, item.char_byte};
		end else if (cnt_q == LEN_W'(1)) begin
			extra_n = {24'd0, item.char_byte};
		end else if (!cnt_q[0]) begin
			hash_n  = (hash_q << 3) + {24'd0, item.char_byte};
			extra_n = extra_q << 2;
		end else begin
			extra_n = extra_q + {24'd0, item.char_byte};
			if (|hash_q[31:29]) begin
				hash_n  = (hash_q ^ (hash_q >> hb)) & mask;
				extra_n = extra_n ^ (extra_n >> hb);
			end
		end
	end

	always_comb begin
		hf = hash_q - extra_q;
		hf = hf ^ (extra_q << (hb >> 1));
		hf = hf ^ (hf >> hb);
		if (cnt_q == '0) hf = 32'd0;
		else if (cnt_q == LEN_W'(1)) hf = hash_q;
		hf = hf & mask;
	end

	assign wb_wr.en   = absorb;
	assign wb_wr.addr = cnt_q[WB_AW-1:0];
	assign wb_wr.data = item.char_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= '0;
			extra_q <= '0;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			job_q   <= 1'b0;
		end else begin
			if (absorb) begin
				hash_q  <= hash_n;
				extra_q <= extra_n;
				cnt_q   <= cnt_q + LEN_W'(1);
			end
			if (accept && item.end_of_word) fin_q <= 1'b1;
			if (fin_q) begin
				fin_q   <= 1'b0;
				job_q   <= 1'b1;
				hash_q  <= '0;
				extra_q <= '0;
				cnt_q   <= '0;
			end else if (job_take) begin
				job_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			job_q_data.bucket <= hf[BKT_W-1:0];
			job_q_data.len    <= cnt_q;
		end
	end

	assign job_valid = job_q;
	assign job       = job_q_data;

endmodule
`default_nettype wire

// ===== hdl/wdf_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wdf_back: chain walk, compare and append
// Owns the bucket heads, links, entry starts, byte store and word buffer.
// Clears the bucket heads after reset, then serves one word at a time.
// ---------------------------------------------------------------------------
module wdf_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire wdf_pkg::wb_wr_t wb_wr,
	input  wire logic          job_valid,
	input  wire wdf_pkg::job_t job,
	output logic               job_take,
	output logic               back_busy,
	output logic               result_valid,
	output wdf_pkg::result_t   result
);
	import wdf_pkg::*;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_HRD  = 4'd2;
	localparam logic [3:0] ST_CHK  = 4'd3;
	localparam logic [3:0] ST_SRD  = 4'd4;
	localparam logic [3:0] ST_CRD  = 4'd5;
	localparam logic [3:0] ST_CCK  = 4'd6;
	localparam logic [3:0] ST_DEC  = 4'd7;
	localparam logic [3:0] ST_CPR  = 4'd8;
	localparam logic [3:0] ST_CPW  = 4'd9;
	localparam logic [3:0] ST_LNK  = 4'd10;
	localparam logic [3:0] ST_LNK2 = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	logic [CNT_W-1:0]  heads_mem [BUCKETS];
	logic [CNT_W-1:0]  links_mem [ENTRIES];
	logic [ADDR_W-1:0] starts_mem [ENTRIES];
	logic [7:0]        bytes_mem [STORE_BYTES];
	logic [7:0]        wbuf_mem [MAX_WORD];

	logic [CNT_W-1:0]  heads_rd, links_rd, heads_wd, links_wd;
	logic [ADDR_W-1:0] starts_rd, heads_ra, heads_wa, bytes_ra, bytes_wa;
	logic [7:0]        bytes_rd, wbuf_rd, bytes_wd;
	logic [IDX_W-1:0]  links_ra, links_wa;
	logic [WB_AW-1:0]  wbuf_ra;
	logic              heads_we, links_we, starts_we, bytes_we;

	logic [3:0]        state_q;
	logic [ADDR_W-1:0] clr_q, s_q;
	logic [BKT_W-1:0]  h_q;
	logic [LEN_W-1:0]  n_q, k_q, want;
	logic [IDX_W-1:0]  cur_q, last_q;
	logic [CNT_W-1:0]  lnk_q, count_q, steps_q;
	logic [FILL_W-1:0] fill_q, at;
	logic              have_q, has_last_q, found_q, full;
	result_t           res_q;

	always_ff @(posedge clk) begin
		if (heads_we) heads_mem[heads_wa] <= heads_wd;
		heads_rd <= heads_mem[heads_ra];
	end
	always_ff @(posedge clk) begin
		if (links_we) links_mem[links_wa] <= links_wd;
		links_rd <= links_mem[links_ra];
	end
	always_ff @(posedge clk) begin
		if (starts_we) starts_mem[count_q[IDX_W-1:0]] <= fill_q[ADDR_W-1:0];
		starts_rd <= starts_mem[links_ra];
	end
	always_ff @(posedge clk) begin
		if (bytes_we) bytes_mem[bytes_wa] <= bytes_wd;
		bytes_rd <= bytes_mem[bytes_ra];
	end
	always_ff @(posedge clk) begin
		if (wb_wr.en) wbuf_mem[wb_wr.addr] <= wb_wr.data;
		wbuf_rd <= wbuf_mem[wbuf_ra];
	end

	assign at   = {1'b0, s_q} + FILL_W'(k_q);
	assign want = (k_q < n_q) ? wbuf_rd : 8'd0;
	assign full = (count_q >= CNT_W'(ENTRIES))
		|| ({1'b0, fill_q} + 18'(n_q) + 18'd1 > 18'(STORE_BYTES));

	always_comb begin
		heads_ra  = job.bucket;
		heads_we  = 1'b0;
		heads_wa  = clr_q;
		heads_wd  = '0;
		links_ra  = cur_q;
		links_we  = 1'b0;
		links_wa  = count_q[IDX_W-1:0];
		links_wd  = '0;
		starts_we = 1'b0;
		bytes_ra  = at[ADDR_W-1:0];
		bytes_we  = 1'b0;
		bytes_wa  = fill_q[ADDR_W-1:0] + ADDR_W'(k_q);
		bytes_wd  = wbuf_rd;
		wbuf_ra   = k_q[WB_AW-1:0];
		unique case (state_q)
			ST_CLR: heads_we = 1'b1;
			ST_CPR: begin
				if (k_q == n_q) begin
					bytes_we = 1'b1;
					bytes_wd = 8'd0;
				end
			end
			ST_CPW: bytes_we = 1'b1;
			ST_LNK: begin
				starts_we = 1'b1;
				links_we  = 1'b1;
			end
			ST_LNK2: begin
				if (has_last_q) begin
					links_we = 1'b1;
					links_wa = last_q;
					links_wd = {1'b1, count_q[IDX_W-1:0]};
				end else begin
					heads_we = 1'b1;
					heads_wa = h_q;
					heads_wd = {1'b1, count_q[IDX_W-1:0]};
				end
			end
			default: ;
		endcase
	end

	assign job_take     = (state_q == ST_IDLE) & job_valid;
	assign back_busy    = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_OUT);
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			count_q <= '0;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (&clr_q) state_q <= ST_IDLE;
				end
				ST_IDLE: if (job_valid) state_q <= ST_HRD;
				ST_HRD:  state_q <= ST_CHK;
				ST_CHK: begin
					if (!have_q || {1'b0, cur_q} >= count_q || steps_q == CNT_W'(ENTRIES))
						state_q <= ST_DEC;
					else
						state_q <= ST_SRD;
				end
				ST_SRD: state_q <= ST_CRD;
				ST_CRD: state_q <= ST_CCK;
				ST_CCK: begin
					if (at[ADDR_W] || bytes_rd != want) state_q <= ST_CHK;
					else if (k_q == n_q) state_q <= ST_DEC;
					else state_q <= ST_CRD;
				end
				ST_DEC: begin
					if (found_q || full) state_q <= ST_OUT;
					else state_q <= ST_CPR;
				end
				ST_CPR: state_q <= (k_q == n_q) ? ST_LNK : ST_CPW;
				ST_CPW: state_q <= ST_CPR;
				ST_LNK: state_q <= ST_LNK2;
				ST_LNK2: begin
					count_q <= count_q + CNT_W'(1);
					fill_q  <= fill_q + FILL_W'(n_q) + FILL_W'(1);
					state_q <= ST_OUT;
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Walk context; none of it needs a reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				h_q        <= job.bucket;
				n_q        <= job.len;
				has_last_q <= 1'b0;
				found_q    <= 1'b0;
				steps_q    <= '0;
			end
			ST_HRD: begin
				have_q <= heads_rd[CNT_W-1];
				cur_q  <= heads_rd[IDX_W-1:0];
			end
			ST_SRD: begin
				s_q   <= starts_rd;
				lnk_q <= links_rd;
				k_q   <= '0;
			end
			ST_CCK: begin
				if (at[ADDR_W] || bytes_rd != want) begin
					last_q     <= cur_q;
					has_last_q <= 1'b1;
					have_q     <= lnk_q[CNT_W-1];
					cur_q      <= lnk_q[IDX_W-1:0];
					steps_q    <= steps_q + CNT_W'(1);
				end else if (k_q == n_q) begin
					found_q <= 1'b1;
				end else begin
					k_q <= k_q + LEN_W'(1);
				end
			end
			ST_DEC: begin
				k_q          <= '0;
				res_q.bucket <= h_q;
				if (found_q) begin
					res_q.verdict     <= VERDICT_DUP;
					res_q.entry_index <= cur_q;
				end else begin
					res_q.verdict     <= VERDICT_FULL;
					res_q.entry_index <= '0;
				end
			end
			ST_CPW: k_q <= k_q + LEN_W'(1);
			ST_LNK2: begin
				res_q.verdict     <= VERDICT_NEW;
				res_q.entry_index <= count_q[IDX_W-1:0];
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== sim/tb_word_duplicate_filter.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_word_duplicate_filter: self-checking bench for the word duplicate filter
// Feeds words byte by byte, predicts every verdict, bucket and entry index
// with its own hash table model and checks each result beat against it.
// ---------------------------------------------------------------------------
module tb_word_duplicate_filter;

	import wdf_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int DRAIN_CYCLES   = 4000;

	logic     clk;
	logic     arst_n;
	logic     start;
	in_item_t item;
	logic     busy;
	logic     cfg_we;
	logic [4:0] cfg_wdata;
	logic     result_valid;
	result_t  result;

	word_duplicate_filter uut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.result_valid(result_valid), .result(result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Predictor state.
	logic [4:0]  hb_reg;
	logic [31:0] h_acc, x_acc;
	int          nchars;
	logic [7:0]  cur_word [MAX_WORD];
	int          head_of [int];
	int          link_of [int];
	int          start_of [ENTRIES];
	logic [7:0]  stored [STORE_BYTES];
	int          n_entries, fill;

	in_item_t pending_beats [$];
	result_t  expected_results [$];
	int       errors;
	bit       quiet_tail;
	int       idle_cnt;

	function automatic int clamp_bits();
		int b;
		b = hb_reg;
		if (b < 1) b = 1;
		if (b > HASH_BITS_MAX) b = HASH_BITS_MAX;
		return b;
	endfunction

	function automatic bit word_equals(int e);
		int s;
		s = start_of[e];
		for (int k = 0; k <= nchars; k++) begin
			if (s + k >= STORE_BYTES) return 0;
			if (stored[s + k] != ((k < nchars) ? cur_word[k] : 8'd0)) return 0;
		end
		return 1;
	endfunction

	task automatic predict_beat(input in_item_t it);
		int b, hb, cur, last, steps;
		logic [31:0] h, msk;
		bit have, has_last, found;
		result_t r;
		b = it.char_byte;
		hb = clamp_bits();
		msk = (32'd1 << hb) - 1;
		if (it.byte_present && b != 0 && nchars < MAX_WORD) begin
			if (nchars == 0) h_acc = b;
			else if (nchars == 1) x_acc = b;
			else if (nchars % 2 == 0) begin
				h_acc = (h_acc << 3) + b;
				x_acc = x_acc << 2;
			end else begin
				x_acc = x_acc + b;
				if (h_acc & 32'he0000000) begin
					h_acc ^= h_acc >> hb;
					x_acc ^= x_acc >> hb;
					h_acc &= msk;
				end
			end
			cur_word[nchars] = 8'(b);
			nchars++;
		end
		if (!it.end_of_word) return;
		if (nchars == 0) h = 0;
		else if (nchars == 1) h = h_acc;
		else begin
			h = h_acc - x_acc;
			h ^= x_acc << (hb / 2);
			h ^= h >> hb;
		end
		h &= msk;
		have = head_of.exists(h);
		cur = have ? head_of[h] : 0;
		last = 0; has_last = 0; found = 0; steps = 0;
		while (have && steps < ENTRIES) begin
			if (cur >= n_entries) break;
			if (word_equals(cur)) begin
				found = 1;
				break;
			end
			last = cur;
			has_last = 1;
			have = link_of.exists(cur);
			cur = have ? link_of[cur] : 0;
			steps++;
		end
		r.bucket = h[15:0];
		if (found) begin
			r.verdict = VERDICT_DUP;
			r.entry_index = IDX_W'(cur);
		end else if (n_entries >= ENTRIES || fill + nchars + 1 > STORE_BYTES) begin
			r.verdict = VERDICT_FULL;
			r.entry_index = '0;
		end else begin
			for (int k = 0; k < nchars; k++) stored[fill + k] = cur_word[k];
			stored[fill + nchars] = 8'd0;
			start_of[n_entries] = fill;
			if (has_last) link_of[last] = n_entries;
			else head_of[h] = n_entries;
			r.verdict = VERDICT_NEW;
			r.entry_index = IDX_W'(n_entries);
			n_entries++;
			fill += nchars + 1;
		end
		expected_results.push_back(r);
		h_acc = 0; x_acc = 0; nchars = 0;
	endtask

	// Driver: one beat offered at a time, with random idle gaps between beats.
	int   gap;
	logic busy_at_edge;

	always @(posedge clk) begin
		busy_at_edge <= busy;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap <= 0;
		end else begin
			if (start && !busy_at_edge) begin
				predict_beat(pending_beats.pop_front());
			end
			if (start && busy_at_edge) begin
				// hold the beat
			end else if (gap > 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (pending_beats.size() > 0) begin
				if (!quiet_tail && $urandom_range(0, 5) == 0) begin
					start <= 1'b0;
					gap <= $urandom_range(0, 2);
				end else begin
					start <= 1'b1;
					item <= pending_beats[0];
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat: verdict %0d bucket %0d entry %0d",
					result.verdict, result.bucket, result.entry_index);
				errors++;
			end else begin
				result_t e;
				e = expected_results.pop_front();
				if (result.verdict !== e.verdict) begin
					$error("verdict: expected %0d, got %0d", e.verdict, result.verdict);
					errors++;
				end
				if (result.bucket !== e.bucket) begin
					$error("bucket: expected %0d, got %0d", e.bucket, result.bucket);
					errors++;
				end
				if (result.entry_index !== e.entry_index) begin
					$error("entry_index: expected %0d, got %0d",
						e.entry_index, result.entry_index);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles without an accepted beat or a result. The limit
	// covers the clearing pass after reset.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic queue_word(input int len, input bit rand_bytes, input logic [7:0] fixed);
		in_item_t it;
		for (int i = 0; i < len; i++) begin
			it.char_byte = rand_bytes ? 8'($urandom_range(1, 255)) : fixed;
			it.byte_present = 1'b1;
			it.end_of_word = (i == len - 1);
			pending_beats.push_back(it);
		end
		if (len == 0) begin
			it = '0;
			it.end_of_word = 1'b1;
			pending_beats.push_back(it);
		end
	endtask

	task automatic wait_idle();
		while (pending_beats.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_bits(input logic [4:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		hb_reg = v;
	endtask

	logic [7:0] vocab [16][12];
	int         vocab_len [16];

	task automatic queue_vocab_word(input int w);
		in_item_t it;
		for (int i = 0; i < vocab_len[w]; i++) begin
			it.char_byte = vocab[w][i];
			it.byte_present = 1'b1;
			it.end_of_word = 1'b0;
			pending_beats.push_back(it);
			if ($urandom_range(0, 15) == 0) begin
				// noise: a lone beat without byte or end, or a zero character
				it.char_byte = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
				it.byte_present = (it.char_byte == 8'd0) ? 1'($urandom_range(0, 1)) : 1'b0;
				pending_beats.push_back(it);
			end
		end
		it = '0;
		it.end_of_word = 1'b1;
		pending_beats.push_back(it);
	endtask

	initial begin
		logic [4:0] phase_bits [5];
		in_item_t   it;
		errors = 0; quiet_tail = 0;
		hb_reg = 5'd16; h_acc = 0; x_acc = 0; nchars = 0; n_entries = 0; fill = 0;
		arst_n = 1'b0; start = 1'b0; item = '0; cfg_we = 1'b0; cfg_wdata = 5'd0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed beats.
		queue_word(0, 1'b0, 8'h00);
		queue_word(1, 1'b0, 8'hff);
		queue_word(1, 1'b0, 8'h01);
		queue_word(1, 1'b0, 8'hff);
		queue_word(2, 1'b0, 8'h80);
		queue_word(MAX_WORD + 5, 1'b0, 8'h7f);
		queue_word(MAX_WORD, 1'b0, 8'h7f);
		queue_word(40, 1'b0, 8'hff);
		it = '0; pending_beats.push_back(it);
		it.char_byte = 8'h00; it.byte_present = 1'b1; it.end_of_word = 1'b1;
		pending_beats.push_back(it);
		it.char_byte = 8'haa; it.byte_present = 1'b0; it.end_of_word = 1'b1;
		pending_beats.push_back(it);
		queue_word(0, 1'b0, 8'h00);
		wait_idle();

		// Register sweep with random traffic; old chains stay behind on change.
		phase_bits = '{5'd0, 5'd31, 5'd1, 5'd9, 5'd16};
		foreach (phase_bits[p]) begin
			write_bits(phase_bits[p]);
			for (int w = 0; w < 16; w++) begin
				vocab_len[w] = $urandom_range(1, 10);
				for (int i = 0; i < 12; i++) vocab[w][i] = 8'($urandom_range(1, 255));
			end
			if (p == 4) quiet_tail = 1;
			for (int n = 0; n < 32; n++) begin
				if ($urandom_range(0, 9) == 0) queue_word($urandom_range(0, 6), 1'b1, 8'h00);
				else queue_vocab_word($urandom_range(0, 15));
			end
			wait_idle();
		end

		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

// ===== word_duplicate_filter.f =====
hdl/wdf_pkg.sv
hdl/wdf_front.sv
hdl/wdf_back.sv
hdl/word_duplicate_filter.sv
sim/tb_word_duplicate_filter.sv
